[rtl/lpe_pkg.sv]
// ---------------------------------------------------------------------------
// lpe_pkg
// shared types, constants and the sensor weight table of the line position
// estimator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpe_pkg;

	localparam int NumSensors = 8;
	localparam int SampleW    = 10;
	localparam int IdxW       = 3;
	localparam int WsumW      = 23;   // |sum| <= 350 * 8 * 1023
	localparam int SsumW      = 13;   // sum <= 8 * 1023
	localparam int MagW       = 22;
	localparam int QuotW      = 9;    // quotient magnitude <= 350
	localparam int PosW       = 10;

	localparam logic signed [11:0] Hyst    = 12'sd12;
	localparam logic [7:0]         AllOn   = 8'hFF;
	localparam logic [7:0]         DeadEnd = 8'h3C;

	typedef logic [NumSensors-1:0][SampleW-1:0] sample_vec_t;

	typedef enum logic [1:0] {
		SCAN_VALID    = 2'd0,
		SCAN_ALL_ON   = 2'd1,
		SCAN_NONE     = 2'd2,
		SCAN_DEAD_END = 2'd3
	} scan_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIV,
		ST_OUT
	} lpe_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	function automatic logic signed [9:0] sensor_weight(input logic [IdxW-1:0] idx);
		logic signed [9:0] w;
		case (idx)
			3'd0:    w = -10'sd350;
			3'd1:    w = -10'sd250;
			3'd2:    w = -10'sd150;
			3'd3:    w = -10'sd50;
			3'd4:    w = 10'sd50;
			3'd5:    w = 10'sd150;
			3'd6:    w = 10'sd250;
			3'd7:    w = 10'sd350;
			default: w = 10'sd0;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

[rtl/lpe_scan_acc.sv]
// ---------------------------------------------------------------------------
// lpe_scan_acc
// walks the eight sensors one per cycle through one compare and
// multiply-accumulate unit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpe_scan_acc (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire lpe_pkg::sample_vec_t              samples,
	input  wire lpe_pkg::sample_vec_t              thresholds,
	input  wire logic [lpe_pkg::NumSensors-1:0]    prev_mask,
	input  wire logic                              white,
	output lpe_pkg::unit_stat_t                    stat,
	output logic [lpe_pkg::NumSensors-1:0]         mask,
	output logic signed [lpe_pkg::WsumW-1:0]       wsum,
	output logic [lpe_pkg::SsumW-1:0]              ssum
);
	import lpe_pkg::*;

	logic                      running_q;
	logic                      done_q;
	logic [IdxW-1:0]           idx_q;
	logic [NumSensors-1:0]     mask_q;
	logic signed [WsumW-1:0]   wsum_q;
	logic [SsumW-1:0]          ssum_q;

	logic signed [11:0]        val_s;
	logic signed [11:0]        thr_s;
	logic signed [11:0]        edge_lvl;
	logic signed [11:0]        diff;
	logic                      is_on;
	logic [SampleW-1:0]        strength;
	logic signed [20:0]        prod;

	always_comb begin
		val_s    = $signed({2'b00, samples[idx_q]});
		thr_s    = $signed({2'b00, thresholds[idx_q]});
		// lower edge when dark and was on, or white and was off
		edge_lvl = (white ^ prev_mask[idx_q]) ? (thr_s - Hyst) : (thr_s + Hyst);
		is_on    = white ? (val_s < edge_lvl) : (val_s > edge_lvl);
		diff     = white ? (thr_s - val_s) : (val_s - thr_s);
		strength = (diff < 12'sd1) ? 10'd1 : diff[SampleW-1:0];
		prod     = sensor_weight(idx_q) * $signed({1'b0, strength});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			idx_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				running_q <= 1'b1;
				idx_q     <= '0;
			end else if (running_q) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == IdxW'(NumSensors - 1)) begin
					running_q <= 1'b0;
					done_q    <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mask_q <= '0;
			wsum_q <= '0;
			ssum_q <= '0;
		end else if (running_q && is_on) begin
			mask_q[idx_q] <= 1'b1;
			wsum_q        <= wsum_q + WsumW'(prod);
			ssum_q        <= ssum_q + SsumW'(strength);
		end
	end

	assign stat.busy = running_q;
	assign stat.done = done_q;
	assign mask      = mask_q;
	assign wsum      = wsum_q;
	assign ssum      = ssum_q;

endmodule

`default_nettype wire

[rtl/lpe_serial_div.sv]
// ---------------------------------------------------------------------------
// lpe_serial_div
// restoring divider, one quotient bit per cycle, sign applied at the end
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpe_serial_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [lpe_pkg::MagW-1:0]      dividend,
	input  wire logic [lpe_pkg::SsumW-1:0]     divisor,
	input  wire logic                          negate,
	output lpe_pkg::unit_stat_t                stat,
	output logic [lpe_pkg::PosW-1:0]           quotient
);
	import lpe_pkg::*;

	localparam int DshW = SsumW + QuotW - 1;

	logic                busy_q;
	logic                done_q;
	logic [3:0]          cnt_q;
	logic [MagW-1:0]     rem_q;
	logic [DshW-1:0]     dsh_q;
	logic [QuotW-1:0]    q_q;
	logic                neg_q;

	logic                ge;
	logic [PosW-1:0]     q_ext;

	assign ge    = rem_q >= {1'b0, dsh_q};
	assign q_ext = {1'b0, q_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'(QuotW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= {divisor, (QuotW - 1)'(0)};
			q_q   <= '0;
			neg_q <= negate;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - {1'b0, dsh_q};
			end
			q_q   <= {q_q[QuotW-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign quotient  = neg_q ? (PosW'(0) - q_ext) : q_ext;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

[rtl/line_position_estimator_unit.sv]
// sequence: an accepted request runs the eight-step sensor walk; when the centroid
// is divided out the nine-step serial divider follows, else (all on, none on,
// dead-end) the result is presented on m_tvalid directly; a new scan request
// is accepted only after the previous result has been taken with m_tready
// reset: arst_n clears the fsm, the hysteresis history and loads all thresholds
// with 512; result payload registers are not reset
// ---------------------------------------------------------------------------
// line_position_estimator_unit
// eight-sensor line position estimator: schmitt-trigger compare per sensor,
// strength-weighted centroid of the sensor positions, status of the scan
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module line_position_estimator_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// scan request
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,   // sample_0 [9:0] .. sample_7 [79:70]
	input  wire logic [1:0]  s_tuser,   // white_line_mode [0], clear_history [1]
	// result
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // line_position [9:0], on_mask [17:10], zero [23:18]
	output logic [1:0]       m_tuser,   // scan_status [1:0]
	// threshold writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [3:0]  cfg_index,
	input  wire logic [9:0]  cfg_data
);
	import lpe_pkg::*;

	// control state
	lpe_state_t            state_q;
	lpe_state_t            state_d;
	logic [NumSensors-1:0] hist_q;

	// thresholds and the captured scan request
	sample_vec_t           thr_q;
	sample_vec_t           samples_q;
	logic                  white_q;
	logic [NumSensors-1:0] prev_q;

	// result registers
	scan_status_t          status_q;
	logic [PosW-1:0]       pos_q;
	logic [NumSensors-1:0] mask_out_q;

	// unit connections
	logic                  in_fire;
	logic                  acc_start;
	logic                  div_start;
	unit_stat_t            acc_stat;
	unit_stat_t            div_stat;
	logic [NumSensors-1:0] acc_mask;
	logic signed [WsumW-1:0] acc_wsum;
	logic [SsumW-1:0]      acc_ssum;
	logic [WsumW-1:0]      wsum_abs;
	logic [PosW-1:0]       div_quot;
	scan_status_t          scan_st;

	assign cfg_ready = 1'b1;
	assign in_fire   = s_tvalid && s_tready;

	// threshold registers, indexes past the last sensor are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumSensors; i++) begin
				thr_q[i] <= 10'd512;
			end
		end else if (cfg_valid && cfg_ready && (cfg_index[3] == 1'b0)) begin
			thr_q[cfg_index[IdxW-1:0]] <= cfg_data;
		end
	end

	// capture the scan; clear_history masks the old on pattern for this scan only
	always_ff @(posedge clk) begin
		if (in_fire) begin
			samples_q <= s_tdata;
			white_q   <= s_tuser[0];
			prev_q    <= s_tuser[1] ? '0 : hist_q;
		end
	end

	// sensor walk: compare, clamp strength, weight and accumulate
	lpe_scan_acc u_acc (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (acc_start),
		.samples    (samples_q),
		.thresholds (thr_q),
		.prev_mask  (prev_q),
		.white      (white_q),
		.stat       (acc_stat),
		.mask       (acc_mask),
		.wsum       (acc_wsum),
		.ssum       (acc_ssum)
	);

	// status priority: all on, then none on, then dead-end
	always_comb begin
		if (acc_mask == AllOn) begin
			scan_st = SCAN_ALL_ON;
		end else if (acc_mask == '0) begin
			scan_st = SCAN_NONE;
		end else if (acc_mask == DeadEnd) begin
			scan_st = SCAN_DEAD_END;
		end else begin
			scan_st = SCAN_VALID;
		end
	end

	// divide magnitudes, the divider restores the sign (truncation toward zero)
	assign wsum_abs = acc_wsum[WsumW-1] ? (WsumW'(0) - acc_wsum) : acc_wsum;

	lpe_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (wsum_abs[MagW-1:0]),
		.divisor  (acc_ssum),
		.negate   (acc_wsum[WsumW-1]),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (acc_stat.done) state_d = (scan_st == SCAN_VALID) ? ST_DIV : ST_OUT;
			end
			ST_DIV: begin
				if (div_stat.done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (m_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		m_tvalid  = (state_q == ST_OUT);
		acc_start = s_tvalid && (state_q == ST_IDLE);
		div_start = (state_q == ST_SCAN) && acc_stat.done && (scan_st == SCAN_VALID);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hist_q  <= '0;
		end else begin
			state_q <= state_d;
			// history follows every scan, valid or not
			if ((state_q == ST_SCAN) && acc_stat.done) begin
				hist_q <= acc_mask;
			end
		end
	end

	// result registers, position stays zero unless the divider ran
	always_ff @(posedge clk) begin
		if ((state_q == ST_SCAN) && acc_stat.done) begin
			status_q   <= scan_st;
			mask_out_q <= acc_mask;
			pos_q      <= '0;
		end else if ((state_q == ST_DIV) && div_stat.done) begin
			pos_q <= div_quot;
		end
	end

	assign m_tdata = {6'b0, mask_out_q, pos_q};
	assign m_tuser = status_q;

	// a scan never overlaps a pending result
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("request taken while result pending");

	// the accumulator only runs inside the scan phase
	a_acc_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		acc_stat.busy |-> (state_q == ST_SCAN))
		else $error("accumulator busy outside scan phase");

	// the divider only runs inside the divide phase
	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> (state_q == ST_DIV))
		else $error("divider busy outside divide phase");

	// any non-valid status carries a zero position
	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (status_q != SCAN_VALID)) |-> (pos_q == '0))
		else $error("nonzero position with invalid status");

	// all-on status agrees with the reported mask
	a_all_on_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (status_q == SCAN_ALL_ON)) |-> (mask_out_q == AllOn))
		else $error("all-on status with partial mask");

endmodule

`default_nettype wire
